@@ sv/rrpg_pkg.sv @@
// ----------------------------------------------------------------------------
// Ring point generator package
// Shared widths, register codes, CORDIC arctangent table, the command and
// status structs between controller and datapath, and rounding helpers.
// ----------------------------------------------------------------------------
package rrpg_pkg;

  // Field widths.
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned VTX_W      = 6;
  localparam int unsigned SPT_W      = 10;
  localparam int unsigned PHI_W      = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Internal widths.
  localparam int unsigned MAG_W    = 17;  // magnitude of the sweep
  localparam int unsigned ANG_W    = 16;  // angle in 1/65536 turn
  localparam int unsigned CORDIC_W = 34;  // CORDIC x, y and z registers
  localparam int unsigned PROD_W   = 2 * COORD_W;

  // Parameter defaults and limits.
  localparam int unsigned MAX_RING_STEPS_DEF    = 63;
  localparam int unsigned CORDIC_ITERATIONS_DEF = 16;
  localparam int unsigned MAX_CORDIC_ITER       = 24;
  localparam int unsigned ITER_W                = $clog2(MAX_CORDIC_ITER);

  // CORDIC gain compensation, 0.607252935 in Q2.30.
  localparam int unsigned GAIN_Q30 = 652032874;

  // Register reset values.
  localparam logic [SPT_W-1:0] SPT_RESET        = SPT_W'(64);
  localparam logic [PHI_W-1:0] PHI_START_RESET  = PHI_W'(0);
  localparam logic [PHI_W-1:0] PHI_LENGTH_RESET = PHI_W'(65536);

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEPS_PER_TURN = 2'd0,
    CFG_PHI_START      = 2'd1,
    CFG_PHI_LENGTH     = 2'd2
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;      // capture a new profile point
    logic              div_step;  // one bit of sweep / steps
    logic              rot_init;  // fold the angle and seed the CORDIC
    logic              rot_step;  // one CORDIC micro-rotation
    logic [ITER_W-1:0] iter;      // micro-rotation index
    logic              mul_x;     // radius times cosine
    logic              mul_y;     // radius times sine, round cosine term
    logic              out_load;  // move the vertex into the output register
    logic              vtx_next;  // advance to the next vertex angle
  } rrpg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;      // current vertex closes the ring
    logic out_free;  // output register can take a word this cycle
  } rrpg_sts_t;

  // atan(2^-k) in 1/2^32 turn.
  function automatic logic [29:0] atan_turn(input logic [ITER_W-1:0] k);
    logic [29:0] r;
    unique case (k)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41722;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      5'd20:   r = 30'd652;
      5'd21:   r = 30'd326;
      5'd22:   r = 30'd163;
      5'd23:   r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Q2.30 product back to Q16.16: round half up, then saturate to 32 bits.
  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] t;
    logic signed [COORD_W-1:0] r;
    t = (p + PROD_W'(64'sd536870912)) >>> 30;
    if (t > PROD_W'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (t < -PROD_W'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = t[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/rrpg_intf.sv @@
// ----------------------------------------------------------------------------
// Ring point generator channels
// Valid/ready interfaces for profile points, ring vertices and register writes.
// ----------------------------------------------------------------------------
interface rrpg_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [rrpg_pkg::COORD_W-1:0]        radius;
  logic signed [rrpg_pkg::COORD_W-1:0]        height;
  logic                                       skip_point;

  modport source (output valid, radius, height, skip_point, input ready);
  modport sink   (input valid, radius, height, skip_point, output ready);
endinterface

interface rrpg_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [rrpg_pkg::COORD_W-1:0]        ring_x;
  logic signed [rrpg_pkg::COORD_W-1:0]        ring_y;
  logic signed [rrpg_pkg::COORD_W-1:0]        ring_z;
  logic        [rrpg_pkg::VTX_W-1:0]          vertex_number;
  logic                                       last_vertex;

  modport source (output valid, ring_x, ring_y, ring_z, vertex_number, last_vertex,
                  input ready);
  modport sink   (input valid, ring_x, ring_y, ring_z, vertex_number, last_vertex,
                  output ready);
endinterface

interface rrpg_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [rrpg_pkg::CFG_IDX_W-1:0]             index;
  logic [rrpg_pkg::CFG_DATA_W-1:0]            data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/revolution_ring_point_generator_top.sv @@
// ----------------------------------------------------------------------------
// Revolution ring point generator
// Turns one profile point into the ring of vertices of a surface of
// revolution, rotating the radius with a shared iterative CORDIC.
// ----------------------------------------------------------------------------
// Usage: write steps_per_turn, phi_start and phi_length on cfg_i while the
// block is idle; writes are never stalled, as ready is always high.
// Each word on in_i is one profile point. A word with skip_point set is
// taken and yields nothing. Any other point yields steps+1 words on out_o,
// the ring vertices at angles i*sweep/steps, numbered from zero, with
// last_vertex set on the closing one.
// Sequence: a point is taken, then a bit-serial divider splits the sweep by
// the step count. Each vertex then folds the angle, runs one micro-rotation
// per iteration on the single shared rotator, uses the one 32x32 multiplier
// twice, and hands the word to the output register. The next point is
// taken once the last vertex sits in the output register.
// A stalled receiver holds the current word in the output register and the
// block waits with the next vertex finished. Reset empties the output,
// returns to idle and restores the register defaults (64, 0, 65536).
// ----------------------------------------------------------------------------
module revolution_ring_point_generator_top #(
  parameter int unsigned MAX_RING_STEPS    = rrpg_pkg::MAX_RING_STEPS_DEF,
  parameter int unsigned CORDIC_ITERATIONS = rrpg_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrpg_cfg_if.sink    cfg_i,
  rrpg_in_if.sink     in_i,
  rrpg_out_if.source  out_o
);

  // Configuration registers. The channel never stalls; a write to an index
  // past the list is taken and ignored.
  logic [rrpg_pkg::SPT_W-1:0] spt_q;
  logic [rrpg_pkg::PHI_W-1:0] phi_start_q;
  logic [rrpg_pkg::PHI_W-1:0] phi_length_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q        <= rrpg_pkg::SPT_RESET;
      phi_start_q  <= rrpg_pkg::PHI_START_RESET;
      phi_length_q <= rrpg_pkg::PHI_LENGTH_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rrpg_pkg::CFG_STEPS_PER_TURN: spt_q        <= cfg_i.data[rrpg_pkg::SPT_W-1:0];
        rrpg_pkg::CFG_PHI_START:      phi_start_q  <= cfg_i.data[rrpg_pkg::PHI_W-1:0];
        rrpg_pkg::CFG_PHI_LENGTH:     phi_length_q <= cfg_i.data[rrpg_pkg::PHI_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rrpg_pkg::rrpg_cmd_t cmd;
  rrpg_pkg::rrpg_sts_t sts;

  // The controller owns the input handshake; the datapath owns the output.
  rrpg_ctrl #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_skip_i  (in_i.skip_point),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrpg_datapath #(
    .MAX_RING_STEPS (MAX_RING_STEPS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .spt_i        (spt_q),
    .phi_start_i  (phi_start_q),
    .phi_length_i (phi_length_q),
    .radius_i     (in_i.radius),
    .height_i     (in_i.height),
    .out_o        (out_o)
  );

endmodule

@@ sv/rrpg_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ring point generator controller
// Sequences the divider, the CORDIC iterations, the multiplies and the output
// hand-off for each vertex of a ring.
// ----------------------------------------------------------------------------
module rrpg_ctrl #(
  parameter int unsigned CORDIC_ITERATIONS = rrpg_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_skip_i,
  output logic                in_ready_o,
  input  rrpg_pkg::rrpg_sts_t sts_i,
  output rrpg_pkg::rrpg_cmd_t cmd_o
);

  localparam int unsigned CNT_W = rrpg_pkg::ITER_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ROT_INIT,
    S_ROT,
    S_MUL_X,
    S_MUL_Y,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.iter = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        // A skipped point is taken and dropped.
        if (in_valid_i && !in_skip_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(rrpg_pkg::MAG_W - 1)) begin
          cnt_d   = '0;
          state_d = S_ROT_INIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_ROT_INIT: begin
        cmd_o.rot_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot_step = 1'b1;
        if (cnt_q == CNT_W'(CORDIC_ITERATIONS - 1)) begin
          state_d = S_MUL_X;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_MUL_X: begin
        cmd_o.mul_x = 1'b1;
        state_d     = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd_o.mul_y = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.vtx_next = 1'b1;
            state_d        = S_ROT_INIT;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // The ring ends with its last vertex and the controller is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && sts_i.last) |=> (state_q == S_IDLE))
    else $error("controller did not return to idle after the last vertex");

  // The angle only advances on a vertex that is handed to the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.vtx_next |-> (cmd_o.out_load && !sts_i.last))
    else $error("vertex advanced without an output word");

  // A point is captured only when a word that is not skipped is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (in_valid_i && in_ready_o && !in_skip_i))
    else $error("point captured without an accepted word");

endmodule

@@ sv/rrpg_datapath.sv @@
// ----------------------------------------------------------------------------
// Ring point generator datapath
// Step count, sweep divider, angle accumulator, shared CORDIC rotator,
// one multiplier with rounding, and the output register.
// ----------------------------------------------------------------------------
module rrpg_datapath #(
  parameter int unsigned MAX_RING_STEPS = rrpg_pkg::MAX_RING_STEPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rrpg_pkg::rrpg_cmd_t                  cmd_i,
  output rrpg_pkg::rrpg_sts_t                  sts_o,
  input  logic [rrpg_pkg::SPT_W-1:0]           spt_i,
  input  logic [rrpg_pkg::PHI_W-1:0]           phi_start_i,
  input  logic [rrpg_pkg::PHI_W-1:0]           phi_length_i,
  input  logic signed [rrpg_pkg::COORD_W-1:0]  radius_i,
  input  logic signed [rrpg_pkg::COORD_W-1:0]  height_i,
  rrpg_out_if.source                           out_o
);

  localparam int unsigned CW    = rrpg_pkg::CORDIC_W;
  localparam int unsigned MW    = rrpg_pkg::MAG_W;
  localparam int unsigned SW    = rrpg_pkg::VTX_W;
  localparam int unsigned DW    = rrpg_pkg::COORD_W;
  localparam int unsigned AW    = rrpg_pkg::ANG_W;
  localparam int unsigned SWP_W = rrpg_pkg::PHI_W + 1;
  localparam int unsigned PRD_W = rrpg_pkg::SPT_W + 1 + SWP_W;
  localparam int unsigned QT_W  = PRD_W - 1 - 16;

  localparam logic signed [CW-1:0] QUARTER = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF    = CW'(64'sd2147483648);

  // Step count and sweep magnitude from the registers.
  logic signed [SWP_W-1:0] sweep_s, sweep_neg;
  logic signed [PRD_W-1:0] prod_s;
  logic [QT_W-1:0]         quot;
  logic [SW-1:0]           steps_d;
  logic [MW-1:0]           mag_d;

  always_comb begin
    sweep_s   = $signed({1'b0, phi_length_i}) - $signed({1'b0, phi_start_i});
    sweep_neg = -sweep_s;
    prod_s    = $signed({1'b0, spt_i}) * sweep_s;
    quot      = prod_s[PRD_W-2:16];
    if (prod_s[PRD_W-1] || (prod_s == '0) || (quot < QT_W'(2))) begin
      steps_d = SW'(2);
    end else if (quot > QT_W'(MAX_RING_STEPS)) begin
      steps_d = SW'(MAX_RING_STEPS);
    end else begin
      steps_d = quot[SW-1:0];
    end
    mag_d = sweep_s[SWP_W-1] ? sweep_neg[MW-1:0] : sweep_s[MW-1:0];
  end

  // Per-point registers.
  logic [SW-1:0]          steps_q;
  logic [MW-1:0]          mag_q;
  logic                   neg_q;
  logic signed [DW-1:0]   radius_q, height_q;

  // Divider: dquo_q ends as mag / steps, rem_q as mag % steps.
  logic [MW-1:0] dquo_q;
  logic [SW-1:0] rem_q;
  logic [SW:0]   trial;
  logic          trial_ge;
  logic [SW:0]   trial_sub;

  // Angle accumulator: q_q is the rounded angle, acc_q its running remainder.
  logic [MW-1:0] q_q;
  logic [SW-1:0] acc_q;
  logic [SW-1:0] vtx_q;
  logic [SW:0]   acc_sum, acc_sub;
  logic          acc_ge;

  always_comb begin
    trial     = {rem_q, dquo_q[MW-1]};
    trial_ge  = (trial >= {1'b0, steps_q});
    trial_sub = trial - {1'b0, steps_q};
    acc_sum   = {1'b0, acc_q} + {1'b0, rem_q};
    acc_ge    = (acc_sum >= {1'b0, steps_q});
    acc_sub   = acc_sum - {1'b0, steps_q};
  end

  // CORDIC.
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic                 flip_q;
  logic [AW-1:0]        phase;
  logic signed [CW-1:0] z0, dx, dy, atan_s;

  always_comb begin
    phase  = neg_q ? (~q_q[AW-1:0] + AW'(1)) : q_q[AW-1:0];
    z0     = CW'($signed({phase, 16'b0}));
    dx     = y_q >>> cmd_i.iter;
    dy     = x_q >>> cmd_i.iter;
    atan_s = $signed(CW'(rrpg_pkg::atan_turn(cmd_i.iter)));
  end

  // Multiplier with the half-turn fold applied to its operand.
  logic signed [CW-1:0]     xs, ys;
  logic signed [DW-1:0]     mop;
  logic signed [2*DW-1:0]   prod_q;
  logic signed [DW-1:0]     rx_q;

  always_comb begin
    xs  = flip_q ? -x_q : x_q;
    ys  = flip_q ? -y_q : y_q;
    mop = cmd_i.mul_x ? $signed(xs[DW-1:0]) : $signed(ys[DW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      steps_q  <= steps_d;
      mag_q    <= mag_d;
      neg_q    <= sweep_s[SWP_W-1];
      radius_q <= radius_i;
      height_q <= height_i;
      dquo_q   <= mag_d;
      rem_q    <= '0;
      q_q      <= '0;
      acc_q    <= steps_d >> 1;
      vtx_q    <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? trial_sub[SW-1:0] : trial[SW-1:0];
      dquo_q <= {dquo_q[MW-2:0], trial_ge};
    end
    if (cmd_i.vtx_next) begin
      vtx_q <= vtx_q + SW'(1);
      if (acc_ge) begin
        acc_q <= acc_sub[SW-1:0];
        q_q   <= q_q + dquo_q + MW'(1);
      end else begin
        acc_q <= acc_sum[SW-1:0];
        q_q   <= q_q + dquo_q;
      end
    end
    if (cmd_i.rot_init) begin
      x_q <= CW'(rrpg_pkg::GAIN_Q30);
      y_q <= '0;
      if (z0 > QUARTER) begin
        z_q    <= z0 - HALF;
        flip_q <= 1'b1;
      end else if (z0 < -QUARTER) begin
        z_q    <= z0 + HALF;
        flip_q <= 1'b1;
      end else begin
        z_q    <= z0;
        flip_q <= 1'b0;
      end
    end
    if (cmd_i.rot_step) begin
      if (!z_q[CW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_s;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_s;
      end
    end
    if (cmd_i.mul_x || cmd_i.mul_y) begin
      prod_q <= radius_q * mop;
    end
    if (cmd_i.mul_y) begin
      rx_q <= rrpg_pkg::round_sat(prod_q);
    end
  end

  // Output register.
  logic                 out_valid_q;
  logic signed [DW-1:0] ring_x_q, ring_y_q, ring_z_q;
  logic [SW-1:0]        vnum_q;
  logic                 vlast_q;
  logic                 last;

  assign last           = (vtx_q == steps_q);
  assign sts_o.last     = last;
  assign sts_o.out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ring_x_q <= rx_q;
      ring_y_q <= rrpg_pkg::round_sat(prod_q);
      ring_z_q <= height_q;
      vnum_q   <= vtx_q;
      vlast_q  <= last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.ring_x        = ring_x_q;
  assign out_o.ring_y        = ring_y_q;
  assign out_o.ring_z        = ring_z_q;
  assign out_o.vertex_number = vnum_q;
  assign out_o.last_vertex   = vlast_q;

  // A word is never written over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_o.ready))
    else $error("output word overwritten before it was taken");

  // The accumulated angle of the closing vertex is the full sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && last) |-> (q_q == mag_q))
    else $error("closing vertex angle differs from the sweep");

  // The step count stays inside its clamp, and the remainder below it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> ((steps_q >= SW'(2)) && (steps_q <= SW'(MAX_RING_STEPS))
                        && (acc_q < steps_q)))
    else $error("step count or angle remainder out of range");

endmodule
